>>> rtl/irn_pkg.sv
// Package with the types, constants and arithmetic helpers of the rotated frame store.
package irn_pkg;

    localparam int CoordW   = 7;
    localparam int DimW     = 7;
    localparam int PixW     = 32;
    localparam int TrigW    = 16;
    localparam int CfgDataW = 16;
    localparam int FracBits = 14;
    localparam int ProdW    = 23;
    localparam int SumW     = 26;

    localparam logic [DimW-1:0] OUT_DIM_MAX = 7'd127;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_COS_Q14    = 2'd2,
        REG_SIN_Q14    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [CoordW-1:0]     pos_x;
        logic [CoordW-1:0]     pos_y;
        logic [PixW-1:0]       pixel_in;
    } item_t;

    typedef struct packed {
        logic [PixW-1:0]       pixel_out;
        logic                  inside_res;
        logic [DimW-1:0]       out_width;
        logic [DimW-1:0]       out_height;
    } result_t;

    // Signed Q1.14 factor times an unsigned 7-bit integer.
    function automatic logic signed [ProdW-1:0] smul(
        input logic signed [TrigW-1:0] a,
        input logic [CoordW-1:0]       b
    );
        logic signed [ProdW-1:0] ae;
        logic signed [ProdW-1:0] be;
        ae = ProdW'(a);
        be = $signed(ProdW'(b));
        return ae * be;
    endfunction

    // Unsigned 7-bit size times an unsigned Q2.14 magnitude.
    function automatic logic [ProdW-1:0] umul(
        input logic [DimW-1:0]  a,
        input logic [TrigW-1:0] b
    );
        return ProdW'(a) * ProdW'(b);
    endfunction

    // Magnitude of a signed Q1.14 value; the most negative code maps to 2^15.
    function automatic logic [TrigW-1:0] mag(input logic signed [TrigW-1:0] a);
        return a[TrigW-1] ? TrigW'(-a) : TrigW'(a);
    endfunction

endpackage

>>> rtl/irn_ram.sv
// Generic single-port RAM with registered read data.
module irn_ram #(
    parameter int Width = 32,
    parameter int Depth = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/image_rotation_nearest.sv
// Top level of the frame store with rotated nearest-neighbor readout.
//
// An item is taken on a rising edge with start high and busy low. A write item
// stores pixel_in at (pos_x, pos_y) of the source image; a read item returns the
// source pixel that the rotated output pixel (pos_x, pos_y) maps to, or zero when
// that point falls outside the source. Every item gives exactly one result beat,
// shown for one cycle with done high; the receiver cannot stall it.
// An accepted item is registered, then passes the product stage, the sum stage,
// the frame store access and its registered read before the result beat.
// Throughput is one item per clock while busy is low.
// The user must write the configuration registers through cfg_wr_en, cfg_index
// and cfg_data only while no item is in flight; the block does not enforce this.
// The output size and centering offsets follow from them through a four-stage
// pipeline, so busy stays high after each write and after reset is released.
// Reset restores the register defaults (64 by 64 source, no rotation). The frame
// store is not cleared; an entry must be written before it is read.
module image_rotation_nearest #(
    parameter int MAX_SIDE = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  irn_pkg::item_t                    item,
    output logic                              done,
    output irn_pkg::result_t                  result,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [irn_pkg::CfgDataW-1:0]      cfg_data
);

    import irn_pkg::*;

    localparam int AddrW = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int SideCap = (MAX_SIDE > 127) ? 127 : MAX_SIDE;
    localparam logic [DimW-1:0] SIDE_CAP = DimW'(SideCap);
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;
    localparam int IntW = SumW - FracBits;
    localparam int DsumW = ProdW + 1;

    // Configuration registers.
    logic [DimW-1:0]         src_width_reg,  src_width_next;
    logic [DimW-1:0]         src_height_reg, src_height_next;
    logic signed [TrigW-1:0] cos_reg,        cos_next;
    logic signed [TrigW-1:0] sin_reg,        sin_next;
    logic [1:0]              settle_reg,     settle_next;

    // Values derived from the configuration.
    logic [DimW-1:0]         w_eff;
    logic [DimW-1:0]         h_eff;
    logic [ProdW-1:0]        wc_reg, wc_next, hs_reg, hs_next;
    logic [ProdW-1:0]        ws_reg, ws_next, hc_reg, hc_next;
    logic [DsumW-1:0]        dsum_w, dsum_h;
    logic [DimW-1:0]         ow_reg, ow_next, oh_reg, oh_next;
    logic [DimW-1:0]         half_w, half_h;
    logic signed [ProdW-1:0] chx_reg, chx_next, shy_reg, shy_next;
    logic signed [ProdW-1:0] shx_reg, shx_next, chy_reg, chy_next;
    logic signed [SumW-1:0]  cxq, cyq;
    logic signed [SumW-1:0]  kx_reg, kx_next, ky_reg, ky_next;

    // Item pipeline.
    logic                    s1_valid_reg, s1_valid_next;
    item_t                   s1_item_reg,  s1_item_next;
    logic                    s2_valid_reg, s2_valid_next;
    item_t                   s2_item_reg,  s2_item_next;
    logic signed [ProdW-1:0] pcx_reg, pcx_next, psy_reg, psy_next;
    logic signed [ProdW-1:0] psx_reg, psx_next, pcy_reg, pcy_next;
    logic                    s3_valid_reg, s3_valid_next;
    item_t                   s3_item_reg,  s3_item_next;
    logic signed [SumW-1:0]  sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic                    s4_valid_reg, s4_valid_next;
    opcode_t                 s4_op_reg,    s4_op_next;
    logic                    s4_inside_reg, s4_inside_next;

    // Frame store access.
    logic                    x_neg, y_neg;
    logic                    x_in, y_in, wr_in, in_bounds;
    logic [CoordW-1:0]       sx, sy, ax, ay;
    logic [31:0]             lin_addr;
    logic                    ram_we;
    logic [AddrW-1:0]        ram_addr;
    logic [PixW-1:0]         ram_rdata;

    // Configuration writes.
    always_comb
    begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        cos_next        = cos_reg;
        sin_next        = sin_reg;
        settle_next     = (settle_reg != '0) ? settle_reg - 2'd1 : settle_reg;
        if (cfg_wr_en)
        begin
            settle_next = SETTLE_CYCLES;
            unique case (cfg_index)
                REG_SRC_WIDTH:  src_width_next  = cfg_data[DimW-1:0];
                REG_SRC_HEIGHT: src_height_next = cfg_data[DimW-1:0];
                REG_COS_Q14:    cos_next        = $signed(cfg_data);
                REG_SIN_Q14:    sin_next        = $signed(cfg_data);
                default:        settle_next     = SETTLE_CYCLES;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 7'd64;
            src_height_reg <= 7'd64;
            cos_reg        <= 16'sd16384;
            sin_reg        <= 16'sd0;
            settle_reg     <= SETTLE_CYCLES;
        end
        else
        begin
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            cos_reg        <= cos_next;
            sin_reg        <= sin_next;
            settle_reg     <= settle_next;
        end
    end

    assign busy = (settle_reg != '0);

    // Output size and centering offsets.
    always_comb
    begin
        w_eff = (src_width_reg  > SIDE_CAP) ? SIDE_CAP : src_width_reg;
        h_eff = (src_height_reg > SIDE_CAP) ? SIDE_CAP : src_height_reg;

        wc_next = umul(w_eff, mag(cos_reg));
        hs_next = umul(h_eff, mag(sin_reg));
        ws_next = umul(w_eff, mag(sin_reg));
        hc_next = umul(h_eff, mag(cos_reg));

        dsum_w  = DsumW'(wc_reg) + DsumW'(hs_reg);
        dsum_h  = DsumW'(ws_reg) + DsumW'(hc_reg);
        ow_next = (dsum_w[DsumW-1:FracBits] > (DsumW-FracBits)'(OUT_DIM_MAX)) ?
                  OUT_DIM_MAX : dsum_w[FracBits+DimW-1:FracBits];
        oh_next = (dsum_h[DsumW-1:FracBits] > (DsumW-FracBits)'(OUT_DIM_MAX)) ?
                  OUT_DIM_MAX : dsum_h[FracBits+DimW-1:FracBits];

        half_w   = ow_reg >> 1;
        half_h   = oh_reg >> 1;
        chx_next = smul(cos_reg, half_w);
        shy_next = smul(sin_reg, half_h);
        shx_next = smul(sin_reg, half_w);
        chy_next = smul(cos_reg, half_h);

        cxq     = $signed(SumW'(w_eff >> 1) << FracBits);
        cyq     = $signed(SumW'(h_eff >> 1) << FracBits);
        kx_next = cxq - SumW'(chx_reg) - SumW'(shy_reg);
        ky_next = cyq + SumW'(shx_reg) - SumW'(chy_reg);
    end

    always_ff @(posedge clk)
    begin
        wc_reg  <= wc_next;
        hs_reg  <= hs_next;
        ws_reg  <= ws_next;
        hc_reg  <= hc_next;
        ow_reg  <= ow_next;
        oh_reg  <= oh_next;
        chx_reg <= chx_next;
        shy_reg <= shy_next;
        shx_reg <= shx_next;
        chy_reg <= chy_next;
        kx_reg  <= kx_next;
        ky_reg  <= ky_next;
    end

    // Rotation products and sums.
    always_comb
    begin
        s1_valid_next = start && !busy;
        s1_item_next  = item;

        s2_valid_next = s1_valid_reg;
        s2_item_next  = s1_item_reg;
        pcx_next      = smul(cos_reg, s1_item_reg.pos_x);
        psy_next      = smul(sin_reg, s1_item_reg.pos_y);
        psx_next      = smul(sin_reg, s1_item_reg.pos_x);
        pcy_next      = smul(cos_reg, s1_item_reg.pos_y);

        s3_valid_next = s2_valid_reg;
        s3_item_next  = s2_item_reg;
        sumx_next     = SumW'(pcx_reg) + SumW'(psy_reg) + kx_reg;
        sumy_next     = SumW'(pcy_reg) - SumW'(psx_reg) + ky_reg;
    end

    // Truncation toward zero, bounds check and store address.
    always_comb
    begin
        x_neg = sumx_reg[SumW-1];
        y_neg = sumy_reg[SumW-1];

        // A negative sum above minus one truncates to column or row zero.
        x_in = x_neg ?
               ((sumx_reg[SumW-1:FracBits] == '1) && (sumx_reg[FracBits-1:0] != '0)
                && (w_eff != '0)) :
               (sumx_reg[SumW-1:FracBits] < IntW'(w_eff));
        y_in = y_neg ?
               ((sumy_reg[SumW-1:FracBits] == '1) && (sumy_reg[FracBits-1:0] != '0)
                && (h_eff != '0)) :
               (sumy_reg[SumW-1:FracBits] < IntW'(h_eff));
        sx = x_neg ? '0 : sumx_reg[FracBits+CoordW-1:FracBits];
        sy = y_neg ? '0 : sumy_reg[FracBits+CoordW-1:FracBits];

        wr_in = (s3_item_reg.pos_x < w_eff) && (s3_item_reg.pos_y < h_eff);

        if (s3_item_reg.opcode == OP_WRITE)
        begin
            in_bounds = wr_in;
            ax        = s3_item_reg.pos_x;
            ay        = s3_item_reg.pos_y;
        end
        else
        begin
            in_bounds = x_in && y_in;
            ax        = sx;
            ay        = sy;
        end

        lin_addr = 32'(ay) * 32'(MAX_SIDE) + 32'(ax);
        ram_addr = lin_addr[AddrW-1:0];
        ram_we   = s3_valid_reg && (s3_item_reg.opcode == OP_WRITE) && in_bounds;

        s4_valid_next  = s3_valid_reg;
        s4_op_next     = s3_item_reg.opcode;
        s4_inside_next = in_bounds;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg   <= s1_item_next;
        s2_item_reg   <= s2_item_next;
        pcx_reg       <= pcx_next;
        psy_reg       <= psy_next;
        psx_reg       <= psx_next;
        pcy_reg       <= pcy_next;
        s3_item_reg   <= s3_item_next;
        sumx_reg      <= sumx_next;
        sumy_reg      <= sumy_next;
        s4_op_reg     <= s4_op_next;
        s4_inside_reg <= s4_inside_next;
    end

    irn_ram #(
        .Width (PixW),
        .Depth (MAX_SIDE * MAX_SIDE)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s3_item_reg.pixel_in),
        .rdata (ram_rdata)
    );

    // Result beat.
    always_comb
    begin
        done              = s4_valid_reg;
        result.pixel_out  = ((s4_op_reg == OP_READ) && s4_inside_reg) ? ram_rdata : '0;
        result.inside_res = s4_inside_reg;
        result.out_width  = ow_reg;
        result.out_height = oh_reg;
    end

endmodule

>>> rtl/irn_chk.sv
// Port-level checker for the rotated frame store, bound to the top level.
module irn_chk (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  irn_pkg::item_t   item,
    input  logic             done,
    input  irn_pkg::result_t result,
    input  logic             cfg_wr_en
);

    import irn_pkg::*;

    // The derived constants must settle before the next item is taken.
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> busy)
        else $error("busy not raised after a configuration write");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result beat missing four cycles after an accepted item");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result beat without a matching accepted item");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.inside_res) |-> (result.pixel_out == '0))
        else $error("nonzero pixel for a point outside the source");

    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(item.opcode == OP_WRITE, 4)) |-> (result.pixel_out == '0))
        else $error("nonzero pixel returned for a write item");

endmodule

bind image_rotation_nearest irn_chk u_irn_chk (.*);
